FILE: hdl/psc_pkg.sv
package psc_pkg;

    // Datapath widths
    localparam int DVD_W   = 31;   // speed scale dividend
    localparam int DVS_W   = 20;   // pulse period divisor
    localparam int CNT_W   = 5;    // divider step counter
    localparam int TGT_W   = 29;   // signed speed setpoint
    localparam int GAIN_W  = 16;   // gains, scaled by 1/1024
    localparam int DUTY_W  = 14;   // PWM compare magnitude
    localparam int INTEG_W = 15;   // signed integral / drive
    localparam int ERR_W   = 33;   // signed speed error
    localparam int PROD_W  = 50;   // gain * error
    localparam int FRAC_W  = 10;   // gain fraction bits
    localparam int SHFT_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = SHFT_W + 1;
    localparam int CIDX_W  = 2;
    localparam int DIR_W   = 2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_TARGET_LEFT  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_TARGET_RIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_INTEG_GAIN   = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_PROP_GAIN    = 2'd3;

    // Tachometer direction codes (code 3 acts as forward)
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_top_state;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_DIV,
        LS_ERR,
        LS_MUL_I,
        LS_MUL_P,
        LS_SUM,
        LS_DONE
    } t_lane_state;

    typedef struct packed {
        logic start;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] duty;
        logic              reverse;
    } t_lane_stat;

    // Saturate a wide signed sum to +-lim
    function automatic logic signed [INTEG_W-1:0] psc_clamp(
        input logic signed [SUM_W-1:0]   x,
        input logic signed [INTEG_W-1:0] lim
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-INTEG_W){lim[INTEG_W-1]}}, lim});
        lo = -hi;
        if (x > hi) begin
            return lim;
        end else if (x < lo) begin
            return -lim;
        end else begin
            return x[INTEG_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/psc_if.sv
interface psc_in_if import psc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DVS_W-1:0] left_period;
    logic [DIR_W-1:0] left_dir;
    logic [DVS_W-1:0] right_period;
    logic [DIR_W-1:0] right_dir;

    modport source (output valid, left_period, left_dir, right_period, right_dir,
                    input ready);
    modport sink   (input valid, left_period, left_dir, right_period, right_dir,
                    output ready);
endinterface

interface psc_out_if import psc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] left_duty;
    logic              left_reverse;
    logic [DUTY_W-1:0] right_duty;
    logic              right_reverse;

    modport source (output valid, left_duty, left_reverse, right_duty, right_reverse,
                    input ready);
    modport sink   (input valid, left_duty, left_reverse, right_duty, right_reverse,
                    output ready);
endinterface

interface psc_cfg_if import psc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [TGT_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/dual_wheel_pi_speed_control_core.sv
// Dual-wheel PI speed controller.
//
// Channels: i_in carries one control tick (pulse period and direction per
// wheel), o_out returns one beat per tick with the PWM magnitude and reverse
// pin of each wheel, i_cfg writes the setpoints and gains by index (0 left
// target, 1 right target, 2 integral gain, 3 proportional gain). Config is
// always ready; write it only while no tick is in flight.
//
// Each wheel has its own lane: a 31-step restoring divider that turns the
// period into speed, then one shared multiplier per lane for the integral
// and proportional products. A tick passes through the divider's 31 steps,
// the divider hand-off, error, two multiply steps, the sum and the output
// load before the output beat is valid. One tick is in flight at a time, so
// a new input beat is taken only once the previous tick's result has been
// loaded into the output register.
//
// Reset clears the integrals, the config registers and all handshake state.
// When the receiver stalls, the result holds in the output register and the
// next tick is still accepted and worked on; its result waits in the lanes
// until the output register frees up.
module dual_wheel_pi_speed_control_core import psc_pkg::*; #(
    parameter int SPEED_SCALE     = 208333333,
    parameter int NO_PULSE_PERIOD = 131072,
    parameter int OUTPUT_LIMIT    = 14999
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psc_in_if.sink    i_in,
    psc_cfg_if.sink   i_cfg,
    psc_out_if.source o_out
);

    t_top_state r_state, n_state;

    // Config registers
    logic signed [TGT_W-1:0] r_target_left;
    logic signed [TGT_W-1:0] r_target_right;
    logic [GAIN_W-1:0]       r_ki;
    logic [GAIN_W-1:0]       r_kp;

    // Output register
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_left_duty;
    logic              r_left_rev;
    logic [DUTY_W-1:0] r_right_duty;
    logic              r_right_rev;

    t_lane_ctl  w_ctl;
    t_lane_stat w_stat_left;
    t_lane_stat w_stat_right;
    logic       w_accept;
    logic       w_load;

    // Config writes: decode index, drop anything past the list
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_left  <= '0;
            r_target_right <= '0;
            r_ki           <= '0;
            r_kp           <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_TARGET_LEFT:  r_target_left  <= i_cfg.data;
                CFG_TARGET_RIGHT: r_target_right <= i_cfg.data;
                CFG_INTEG_GAIN:   r_ki           <= i_cfg.data[GAIN_W-1:0];
                CFG_PROP_GAIN:    r_kp           <= i_cfg.data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Merge: both lanes finish on the same cycle; load once the output
    // register is empty or being drained this cycle
    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == ST_RUN) && w_stat_left.done && w_stat_right.done
                    && (!r_out_valid || o_out.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_RUN;
            ST_RUN:  if (w_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        i_in.ready  = (r_state == ST_IDLE);
        w_ctl.start = w_accept;
        w_ctl.ack   = w_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_left_duty  <= w_stat_left.duty;
            r_left_rev   <= w_stat_left.reverse;
            r_right_duty <= w_stat_right.duty;
            r_right_rev  <= w_stat_right.reverse;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.left_duty     = r_left_duty;
    assign o_out.left_reverse  = r_left_rev;
    assign o_out.right_duty    = r_right_duty;
    assign o_out.right_reverse = r_right_rev;

    psc_lane #(
        .SPEED_SCALE     (SPEED_SCALE),
        .NO_PULSE_PERIOD (NO_PULSE_PERIOD),
        .OUTPUT_LIMIT    (OUTPUT_LIMIT)
    ) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_period (i_in.left_period),
        .i_dir    (i_in.left_dir),
        .i_target (r_target_left),
        .i_ki     (r_ki),
        .i_kp     (r_kp),
        .o_stat   (w_stat_left)
    );

    psc_lane #(
        .SPEED_SCALE     (SPEED_SCALE),
        .NO_PULSE_PERIOD (NO_PULSE_PERIOD),
        .OUTPUT_LIMIT    (OUTPUT_LIMIT)
    ) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_period (i_in.right_period),
        .i_dir    (i_in.right_dir),
        .i_target (r_target_right),
        .i_ki     (r_ki),
        .i_kp     (r_kp),
        .o_stat   (w_stat_right)
    );

    // Lanes run in lockstep
    a_lanes_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat_left.done == w_stat_right.done)
        else $error("lane done flags diverged");

    // A fresh output beat only follows a tick in flight
    a_out_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> $past(r_state == ST_RUN || w_accept))
        else $error("output loaded without a tick in flight");

    // Duty stays within the drive limit
    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_left_duty <= DUTY_W'(OUTPUT_LIMIT))
                     && (r_right_duty <= DUTY_W'(OUTPUT_LIMIT)))
        else $error("duty beyond output limit");

    // Reverse pin never set with zero drive
    a_rev_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_left_rev || r_right_rev) |->
            (!r_left_rev || r_left_duty != '0) && (!r_right_rev || r_right_duty != '0))
        else $error("reverse set with zero duty");

    // Stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_out_valid && !o_out.ready) |-> r_out_valid && $stable(r_left_duty)
                                             && $stable(r_right_duty))
        else $error("stalled result changed");

endmodule

FILE: hdl/psc_div.sv
module psc_div import psc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;    // dividend bits shift out, quotient bits shift in
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_qbit;

    // One restoring step per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_qbit  = (w_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

FILE: hdl/psc_lane.sv
module psc_lane import psc_pkg::*; #(
    parameter int SPEED_SCALE     = 208333333,
    parameter int NO_PULSE_PERIOD = 131072,
    parameter int OUTPUT_LIMIT    = 14999
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic [DVS_W-1:0]         i_period,
    input  logic [DIR_W-1:0]         i_dir,
    input  logic signed [TGT_W-1:0]  i_target,
    input  logic [GAIN_W-1:0]        i_ki,
    input  logic [GAIN_W-1:0]        i_kp,
    output t_lane_stat               o_stat
);

    localparam logic [DVD_W-1:0]          SCALE_V = DVD_W'(SPEED_SCALE);
    localparam logic [DVS_W-1:0]          NOPLS_V = DVS_W'(NO_PULSE_PERIOD);
    localparam logic signed [INTEG_W-1:0] LIM_V   = INTEG_W'(OUTPUT_LIMIT);

    t_lane_state r_state, n_state;

    logic [DIR_W-1:0]          r_dir;
    logic signed [ERR_W-1:0]   r_err;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [INTEG_W-1:0] r_integ;
    logic [DUTY_W-1:0]         r_duty;
    logic                      r_rev;

    logic                      w_div_start;
    logic                      w_div_done;
    logic [DVD_W-1:0]          w_quot;
    logic [DVS_W-1:0]          w_divisor;
    logic signed [ERR_W-1:0]   w_tgt_ext;
    logic signed [ERR_W-1:0]   w_q_ext;
    logic [GAIN_W-1:0]         w_gain;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SHFT_W-1:0]  w_pshift;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [INTEG_W-1:0] w_clamped;
    logic signed [INTEG_W-1:0] w_mag;
    logic                      w_stopped;

    assign w_divisor = (i_period == '0) ? NOPLS_V : i_period;

    psc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (SCALE_V),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            LS_IDLE:  if (i_ctl.start) n_state = LS_DIV;
            LS_DIV:   if (w_div_done) n_state = LS_ERR;
            LS_ERR:   n_state = LS_MUL_I;
            LS_MUL_I: n_state = LS_MUL_P;
            LS_MUL_P: n_state = LS_SUM;
            LS_SUM:   n_state = LS_DONE;
            LS_DONE:  if (i_ctl.ack) n_state = LS_IDLE;
            default:  n_state = LS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        w_div_start    = (r_state == LS_IDLE) && i_ctl.start;
        o_stat.done    = (r_state == LS_DONE);
        o_stat.duty    = r_duty;
        o_stat.reverse = r_rev;
    end

    // Shared multiplier: integral gain first, proportional gain next
    always_comb begin
        w_tgt_ext = $signed({{(ERR_W-TGT_W){i_target[TGT_W-1]}}, i_target});
        w_q_ext   = $signed({{(ERR_W-DVD_W){1'b0}}, w_quot});
        w_gain    = (r_state == LS_MUL_I) ? i_ki : i_kp;
        w_prod    = $signed({1'b0, w_gain}) * r_err;
        w_pshift  = r_prod[PROD_W-1:FRAC_W];
        w_sum     = $signed({{(SUM_W-INTEG_W){r_integ[INTEG_W-1]}}, r_integ})
                  + $signed({w_pshift[SHFT_W-1], w_pshift});
        w_clamped = psc_clamp(w_sum, LIM_V);
        w_mag     = -w_clamped;
        w_stopped = (i_target == '0) && (r_dir == DIR_STOP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LS_IDLE;
            r_integ <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == LS_MUL_P) begin
                r_integ <= w_clamped;
            end else if (r_state == LS_SUM && w_stopped) begin
                r_integ <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_dir <= i_dir;
        end
        if (r_state == LS_ERR) begin
            r_err <= (r_dir == DIR_REV) ? (w_tgt_ext + w_q_ext) : (w_tgt_ext - w_q_ext);
        end
        if (r_state == LS_MUL_I || r_state == LS_MUL_P) begin
            r_prod <= w_prod;
        end
        if (r_state == LS_SUM) begin
            if (w_stopped || w_clamped == '0) begin
                r_duty <= '0;
                r_rev  <= 1'b0;
            end else if (w_clamped < 0) begin
                r_duty <= w_mag[DUTY_W-1:0];
                r_rev  <= 1'b1;
            end else begin
                r_duty <= w_clamped[DUTY_W-1:0];
                r_rev  <= 1'b0;
            end
        end
    end

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    // Block parameters, kept in step with the instance below
    localparam int SPEED_SCALE     = 208333333;
    localparam int NO_PULSE_PERIOD = 131072;
    localparam int OUTPUT_LIMIT    = 14999;

    // Direction code 3 is not named in the package; the block runs it as forward
    localparam logic [DIR_W-1:0] DIR_ALT_FWD = 2'd3;

    // Setpoint codes at the edges of the 29-bit field
    localparam logic [TGT_W-1:0] TGT_POS_MAX = 29'h0FFF_FFFF;
    localparam logic [TGT_W-1:0] TGT_NEG_MAX = 29'h1000_0001;
    localparam logic [TGT_W-1:0] TGT_NEG_END = 29'h1000_0000;

    localparam int DRAIN_PAD   = 45;    // a margin over one tick's latency
    localparam int QUIET_LIMIT = 5000;  // cycles with no beat before giving up

    typedef struct packed {
        logic [DVS_W-1:0] left_period;
        logic [DIR_W-1:0] left_dir;
        logic [DVS_W-1:0] right_period;
        logic [DIR_W-1:0] right_dir;
    } t_tacho;

    typedef struct packed {
        logic [DUTY_W-1:0] left_duty;
        logic              left_reverse;
        logic [DUTY_W-1:0] right_duty;
        logic              right_reverse;
    } t_drive;

    logic i_clk;
    logic i_rst_n;

    psc_in_if  in_if ();
    psc_cfg_if cfg_if ();
    psc_out_if out_if ();

    dual_wheel_pi_speed_control_core #(
        .SPEED_SCALE     (SPEED_SCALE),
        .NO_PULSE_PERIOD (NO_PULSE_PERIOD),
        .OUTPUT_LIMIT    (OUTPUT_LIMIT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // Controller copy: setpoints, gains and the two integrators
    logic signed [TGT_W-1:0]   tgt_left;
    logic signed [TGT_W-1:0]   tgt_right;
    logic [GAIN_W-1:0]         gain_i;
    logic [GAIN_W-1:0]         gain_p;
    logic signed [INTEG_W-1:0] integ_left;
    logic signed [INTEG_W-1:0] integ_right;

    // Drive beats owed by the block, oldest first
    t_drive pending_drives[$];

    int n_ticks;
    int n_drives;
    int n_settings;
    int n_mismatch;

    // Pacing knobs, changed per test
    int  gap_pct;
    int  stall_pct;
    bit  steady;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Controller arithmetic
    // ------------------------------------------------------------------
    function automatic longint limit_drive(input longint x);
        if (x > OUTPUT_LIMIT) return OUTPUT_LIMIT;
        if (x < -OUTPUT_LIMIT) return -OUTPUT_LIMIT;
        return x;
    endfunction

    // One wheel for one tick: measure speed, step the integrator, form the drive.
    // Products stay exact in 64 bits; >>> floors toward minus infinity.
    function automatic void wheel_drive(
        input  logic [DVS_W-1:0]          period,
        input  logic [DIR_W-1:0]          dir,
        input  logic signed [TGT_W-1:0]   target,
        inout  logic signed [INTEG_W-1:0] integ,
        output logic [DUTY_W-1:0]         duty,
        output logic                      rev
    );
        longint denom;
        longint speed;
        longint err;
        longint acc;
        longint drive;
        denom = (period == '0) ? longint'(NO_PULSE_PERIOD) : longint'(period);
        speed = longint'(SPEED_SCALE) / denom;
        if (dir == DIR_REV) speed = -speed;
        err = longint'(target) - speed;

        acc   = limit_drive(longint'(integ) + ((longint'(gain_i) * err) >>> FRAC_W));
        drive = acc + ((longint'(gain_p) * err) >>> FRAC_W);

        // A stopped wheel with a zero setpoint drops its integrator and drive
        if (target == '0 && dir == DIR_STOP) begin
            acc   = 0;
            drive = 0;
        end
        drive = limit_drive(drive);

        integ = acc[INTEG_W-1:0];
        rev   = (drive < 0);
        duty  = DUTY_W'(rev ? -drive : drive);
    endfunction

    function automatic t_drive predict_drive(input t_tacho t);
        t_drive d;
        wheel_drive(t.left_period, t.left_dir, tgt_left, integ_left,
                    d.left_duty, d.left_reverse);
        wheel_drive(t.right_period, t.right_dir, tgt_right, integ_right,
                    d.right_duty, d.right_reverse);
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_tacho tacho(input logic [DVS_W-1:0] lp, input logic [DIR_W-1:0] ld,
                                     input logic [DVS_W-1:0] rp, input logic [DIR_W-1:0] rd);
        t_tacho t;
        t.left_period  = lp;
        t.left_dir     = ld;
        t.right_period = rp;
        t.right_dir    = rd;
        return t;
    endfunction

    function automatic logic [DVS_W-1:0] pick_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return DVS_W'(1);
            2:       return DVS_W'($urandom_range(16, 2));
            3:       return '1;
            4, 5:    return DVS_W'($urandom);
            default: return DVS_W'($urandom_range(300000, 6000));
        endcase
    endfunction

    function automatic logic [DIR_W-1:0] pick_dir();
        case ($urandom_range(9))
            0, 1, 2, 3: return DIR_FWD;
            4, 5, 6:    return DIR_REV;
            7, 8:       return DIR_STOP;
            default:    return DIR_ALT_FWD;
        endcase
    endfunction

    function automatic logic [TGT_W-1:0] pick_target();
        logic signed [TGT_W-1:0] v;
        case ($urandom_range(9))
            0, 1:    return '0;
            2:       return TGT_POS_MAX;
            3:       return TGT_NEG_MAX;
            4:       return TGT_NEG_END;
            5:       return TGT_W'($urandom);
            default: begin
                v = TGT_W'($urandom_range(30000));
                return $urandom_range(1) ? -v : v;
            end
        endcase
    endfunction

    // Gain word: random bits above the 16-bit gain check that they are dropped
    function automatic logic [TGT_W-1:0] pick_gain();
        logic [GAIN_W-1:0] g;
        case ($urandom_range(7))
            0:       g = '0;
            1:       g = '1;
            2, 3:    g = GAIN_W'($urandom_range(64, 1));
            4, 5:    g = GAIN_W'($urandom_range(2048, 65));
            default: g = GAIN_W'($urandom);
        endcase
        return {(TGT_W-GAIN_W)'($urandom), g};
    endfunction

    // Direction that mostly agrees with the setpoint sign, as a running wheel would
    function automatic logic [DIR_W-1:0] follow_dir(input logic signed [TGT_W-1:0] target);
        case ($urandom_range(19))
            0, 1:    return DIR_STOP;
            2:       return DIR_ALT_FWD;
            3:       return (target < 0) ? DIR_FWD : DIR_REV;
            default: return (target < 0) ? DIR_REV : DIR_FWD;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Channel tasks
    // ------------------------------------------------------------------
    // Write one register; valid stays up so a following write does not bounce it.
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [TGT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            CFG_TARGET_LEFT:  tgt_left  = data;
            CFG_TARGET_RIGHT: tgt_right = data;
            CFG_INTEG_GAIN:   gain_i    = data[GAIN_W-1:0];
            CFG_PROP_GAIN:    gain_p    = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [TGT_W-1:0] tl, input logic [TGT_W-1:0] tr,
                                  input logic [TGT_W-1:0] gi, input logic [TGT_W-1:0] gp);
        write_reg(CFG_TARGET_LEFT, tl);
        write_reg(CFG_TARGET_RIGHT, tr);
        write_reg(CFG_INTEG_GAIN, gi);
        write_reg(CFG_PROP_GAIN, gp);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    // Send one tick. Idle comes as a run of short bursts so that the next beat
    // can land anywhere in the block's working window.
    task automatic send_tick(input t_tacho t);
        int bursts;
        if (!steady && $urandom_range(99) < gap_pct) begin
            in_if.valid <= 1'b0;
            {in_if.left_period, in_if.left_dir, in_if.right_period, in_if.right_dir}
                <= t_tacho'({$urandom, $urandom});
            bursts = $urandom_range(6, 1);
            repeat (bursts) repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.left_period  <= t.left_period;
        in_if.left_dir     <= t.left_dir;
        in_if.right_period <= t.right_period;
        in_if.right_dir    <= t.right_dir;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        pending_drives.push_back(predict_drive(t));
        n_ticks++;
    endtask

    // Drop valid and hold until every drive beat is back and the block is quiet
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Registers still at reset: zero setpoints and gains give zero drive
    task automatic test_reset_state();
        gap_pct   = 30;
        stall_pct = 10;
        send_tick(tacho('0, DIR_FWD, '1, DIR_REV));
        send_tick(tacho(DVS_W'(1), DIR_STOP, DVS_W'(1), DIR_ALT_FWD));
        send_tick(tacho('1, DIR_REV, '0, DIR_STOP));
        drain();
    endtask

    // Full-scale setpoints, gains and periods: wheels pinned at the limit unless stopped at a zero setpoint
    task automatic test_field_extremes();
        apply_settings(TGT_POS_MAX, TGT_NEG_MAX, '1, '1);
        send_tick(tacho(DVS_W'(1), DIR_REV, DVS_W'(1), DIR_FWD));
        send_tick(tacho('1, DIR_FWD, '1, DIR_REV));
        send_tick(tacho('0, DIR_ALT_FWD, '0, DIR_STOP));
        send_tick(tacho(20'h55555, DIR_FWD, 20'hAAAAA, DIR_REV));
        send_tick(tacho(20'hAAAAA, DIR_STOP, 20'h55555, DIR_ALT_FWD));
        drain();
        // Most negative setpoint code, zero integral gain, upper proportional-gain data bits clear
        apply_settings(TGT_NEG_END, '0, {(TGT_W-GAIN_W)'($urandom), {GAIN_W{1'b0}}},
                       {{(TGT_W-GAIN_W){1'b0}}, {GAIN_W{1'b1}}});
        send_tick(tacho(DVS_W'(1), DIR_FWD, DVS_W'(1), DIR_STOP));
        send_tick(tacho('0, DIR_REV, DVS_W'(1), DIR_REV));
        send_tick(tacho(DVS_W'(2), DIR_ALT_FWD, DVS_W'(3), DIR_FWD));
        send_tick(tacho('1, DIR_STOP, '1, DIR_STOP));
        drain();
    endtask

    // Wind the integrators up, then stop each wheel at zero setpoint to clear them
    task automatic test_stop_clears_integral();
        apply_settings('0, '0, TGT_W'(300), TGT_W'(200));
        send_tick(tacho(DVS_W'(7000), DIR_FWD, DVS_W'(9000), DIR_REV));
        send_tick(tacho(DVS_W'(7000), DIR_FWD, DVS_W'(9000), DIR_REV));
        send_tick(tacho(DVS_W'(12000), DIR_FWD, DVS_W'(20000), DIR_REV));
        send_tick(tacho(DVS_W'(7000), DIR_STOP, DVS_W'(9000), DIR_STOP));
        send_tick(tacho('0, DIR_STOP, '0, DIR_ALT_FWD));
        send_tick(tacho(DVS_W'(7000), DIR_REV, '0, DIR_STOP));
        drain();
    endtask

    // Small gains and errors: negative products must floor, not truncate
    task automatic test_floor_rounding();
        apply_settings(-TGT_W'(5), TGT_W'(5), TGT_W'(1), TGT_W'(3));
        send_tick(tacho('1, DIR_FWD, '1, DIR_REV));
        send_tick(tacho('0, DIR_REV, '1, DIR_FWD));
        send_tick(tacho(DVS_W'(300000), DIR_STOP, DVS_W'(300000), DIR_STOP));
        send_tick(tacho('1, DIR_ALT_FWD, '0, DIR_STOP));
        drain();
    endtask

    // Random settings, each followed by a batch of arbitrary ticks
    task automatic test_random_settings(input int phases, input int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            gap_pct   = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
            stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(30, 2);
            apply_settings(pick_target(), pick_target(), pick_gain(), pick_gain());
            repeat (per_phase)
                send_tick(tacho(pick_period(), pick_dir(), pick_period(), pick_dir()));
            drain();
        end
    endtask

    // Wheels running near their setpoints with modest gains, so the
    // integrators move through their whole range instead of sitting at a rail
    task automatic test_speed_tracking(input int phases, input int per_phase);
        logic signed [TGT_W-1:0] tl;
        logic signed [TGT_W-1:0] tr;
        for (int ph = 0; ph < phases; ph++) begin
            gap_pct   = $urandom_range(40);
            stall_pct = $urandom_range(20);
            tl = (ph == 0) ? '0 : TGT_W'($urandom_range(30000, 500));
            tr = TGT_W'($urandom_range(30000, 500));
            if ($urandom_range(1)) tl = -tl;
            if ($urandom_range(1)) tr = -tr;
            apply_settings(tl, tr, TGT_W'($urandom_range(64, 1)),
                           TGT_W'($urandom_range(1024, 16)));
            repeat (per_phase)
                send_tick(tacho(DVS_W'($urandom_range(300000, 6000)), follow_dir(tl),
                                DVS_W'($urandom_range(300000, 6000)), follow_dir(tr)));
            drain();
        end
    endtask

    // No gaps and no stalls: ticks go in as fast as the block takes them
    task automatic test_back_to_back(input int count);
        steady = 1'b1;
        apply_settings(pick_target(), pick_target(), pick_gain(), pick_gain());
        repeat (count)
            send_tick(tacho(pick_period(), pick_dir(), pick_period(), pick_dir()));
        drain();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    // Receiver pacing: ready drops for a run of bursts of random length; a long run
    // lets the next tick finish while the previous beat is still held.
    initial begin : sink_pacing
        int bursts;
        out_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (!steady && $urandom_range(99) < stall_pct) begin
                out_if.ready <= 1'b0;
                bursts = ($urandom_range(5) == 0) ? $urandom_range(8, 4) : 1;
                repeat (bursts) repeat ($urandom_range(7, 1)) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            n_mismatch++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $realtime, what, want, got);
        end
    endfunction

    // Compare every drive beat with the oldest prediction
    always @(posedge i_clk) begin : drive_monitor
        t_drive want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            n_drives++;
            if (pending_drives.size() == 0) begin
                n_mismatch++;
                $display("%0t ns: drive beat with nothing pending, expected none actual %0d/%0d %0d/%0d",
                         $realtime, out_if.left_duty, out_if.left_reverse,
                         out_if.right_duty, out_if.right_reverse);
            end else begin
                want = pending_drives.pop_front();
                check_field("left_duty", int'(want.left_duty), int'(out_if.left_duty));
                check_field("left_reverse", int'(want.left_reverse),
                            int'(out_if.left_reverse));
                check_field("right_duty", int'(want.right_duty), int'(out_if.right_duty));
                check_field("right_reverse", int'(want.right_reverse),
                            int'(out_if.right_reverse));
            end
        end
    end

    // Watchdog: give up once no beat has moved on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no beat for %0d cycles, %0d drive beats still pending",
                 $realtime, QUIET_LIMIT, pending_drives.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        n_ticks     = 0;
        n_drives    = 0;
        n_settings  = 0;
        n_mismatch  = 0;
        gap_pct     = 0;
        stall_pct   = 0;
        steady      = 1'b0;
        tgt_left    = '0;
        tgt_right   = '0;
        gain_i      = '0;
        gain_p      = '0;
        integ_left  = '0;
        integ_right = '0;

        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.left_period  <= '0;
        in_if.left_dir     <= DIR_FWD;
        in_if.right_period <= '0;
        in_if.right_dir    <= DIR_FWD;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_TARGET_LEFT;
        cfg_if.data        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_field_extremes();
        test_stop_clears_integral();
        test_floor_rounding();
        test_random_settings(6, 220);
        test_speed_tracking(3, 150);
        test_back_to_back(200);

        $display("Sent %0d ticks across %0d register settings; %0d drive beats compared.",
                 n_ticks, n_settings, n_drives);
        $display("Covered saturation, stop-and-clear, floor rounding and stalls; %0d mismatches.",
                 n_mismatch);
        if (n_mismatch == 0 && pending_drives.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
